### src/gsa_pkg.sv
// ----------------------------------------------------------------------------
// Grid slot allocator package
// Shared sizes, codes and the structures passed between the controller and
// the chain of row cells.
// ----------------------------------------------------------------------------
package gsa_pkg;

    // Stored grid size.
    localparam int MAX_COLS = 16;
    localparam int MAX_ROWS = 16;

    // Index and count widths derived from the grid size.
    localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_C_W = $clog2(MAX_COLS + 1);
    localparam int CNT_R_W = $clog2(MAX_ROWS + 1);

    // Field widths fixed by the interface.
    localparam int IN_W     = 5;
    localparam int SLOT_W   = 4;
    localparam int POS_W    = 16;
    localparam int STEP_W   = 12;
    localparam int CNT_CFG_W = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Operation codes.
    typedef enum logic [0:0] {
        OP_REQ  = 1'b0,
        OP_FREE = 1'b1
    } t_op;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLS     = 3'd0,
        CFG_ROWS     = 3'd1,
        CFG_ORIGIN_X = 3'd2,
        CFG_ORIGIN_Y = 3'd3,
        CFG_STEP_X   = 3'd4,
        CFG_STEP_Y   = 3'd5,
        CFG_TOP      = 3'd6
    } t_cfg_idx;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_DONE
    } t_state;

    // Search token that travels down the chain of row cells.
    typedef struct packed {
        logic               vld;
        t_op                op;
        logic               in_grid;
        logic               hint_ok;
        logic [COL_W-1:0]   hcol;
        logic [ROW_W-1:0]   hrow;
        logic [CNT_C_W-1:0] cols;
        logic [CNT_R_W-1:0] rows;
        logic               hint_free;
        logic               ff_found;
        logic [COL_W-1:0]   ff_col;
        logic [ROW_W-1:0]   ff_row;
        logic               free_ok;
    } t_token;

    // Broadcast write that marks one slot as occupied.
    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_row_wr;

endpackage

### src/gsa_if.sv
// ----------------------------------------------------------------------------
// Grid slot allocator channel interfaces
// Request, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface gsa_req_if;
    logic                           valid;
    logic                           ready;
    logic                           op;
    logic signed [gsa_pkg::IN_W-1:0] col;
    logic signed [gsa_pkg::IN_W-1:0] row;

    modport source (output valid, output op, output col, output row, input ready);
    modport sink   (input valid, input op, input col, input row, output ready);
endinterface

interface gsa_res_if;
    logic                             valid;
    logic                             ready;
    logic                             ok;
    logic signed [gsa_pkg::POS_W-1:0] pos_x;
    logic signed [gsa_pkg::POS_W-1:0] pos_y;
    logic [gsa_pkg::SLOT_W-1:0]       slot_col;
    logic [gsa_pkg::SLOT_W-1:0]       slot_row;
    logic                             full_res;

    modport source (output valid, output ok, output pos_x, output pos_y,
                    output slot_col, output slot_row, output full_res, input ready);
    modport sink   (input valid, input ok, input pos_x, input pos_y,
                    input slot_col, input slot_row, input full_res, output ready);
endinterface

interface gsa_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [gsa_pkg::CFG_IDX_W-1:0]      index;
    logic [gsa_pkg::CFG_DAT_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/gsa_cell.sv
// ----------------------------------------------------------------------------
// Grid slot allocator row cell
// Holds the occupancy bits of one grid row and updates the passing search
// token with hint, first-fit and free results for that row.
// ----------------------------------------------------------------------------
module gsa_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [gsa_pkg::ROW_W-1:0]   i_row_idx,
    input  gsa_pkg::t_token             i_tok,
    input  gsa_pkg::t_row_wr            i_wr,
    output gsa_pkg::t_token             o_tok
);

    logic [gsa_pkg::MAX_COLS-1:0] r_bits;
    logic [gsa_pkg::MAX_COLS-1:0] n_bits;
    logic [gsa_pkg::MAX_COLS-1:0] free_vec;
    logic                         r_vld;
    gsa_pkg::t_token              r_tok;
    gsa_pkg::t_token              n_tok;
    logic                         row_here;
    logic                         bit_at;
    logic                         row_in_use;
    logic                         any_free;
    logic [gsa_pkg::COL_W-1:0]    first_col;

    // Free slots of this row inside the columns in use.
    always_comb begin
        for (int i = 0; i < gsa_pkg::MAX_COLS; i++) begin
            free_vec[i] = !r_bits[i] && (gsa_pkg::CNT_C_W'(i) < i_tok.cols);
        end
    end

    // Lowest free column of this row.
    always_comb begin
        first_col = '0;
        for (int i = gsa_pkg::MAX_COLS - 1; i >= 0; i--) begin
            if (free_vec[i]) begin
                first_col = gsa_pkg::COL_W'(i);
            end
        end
    end

    assign any_free   = |free_vec;
    assign row_in_use = gsa_pkg::CNT_R_W'(i_row_idx) < i_tok.rows;
    assign row_here   = (i_tok.hrow == i_row_idx);
    assign bit_at     = r_bits[i_tok.hcol];

    // Token update and occupancy update for this row.
    always_comb begin
        n_tok  = i_tok;
        n_bits = r_bits;
        if (i_tok.vld) begin
            if (i_tok.op == gsa_pkg::OP_FREE) begin
                if (i_tok.in_grid && row_here) begin
                    n_tok.free_ok     = bit_at;
                    n_bits[i_tok.hcol] = 1'b0;
                end
            end else begin
                if (i_tok.hint_ok && row_here) begin
                    n_tok.hint_free = !bit_at;
                end
                if (!i_tok.ff_found && row_in_use && any_free) begin
                    n_tok.ff_found = 1'b1;
                    n_tok.ff_col   = first_col;
                    n_tok.ff_row   = i_row_idx;
                end
            end
        end
        if (i_wr.en && (i_wr.row == i_row_idx)) begin
            n_bits[i_wr.col] = 1'b1;
        end
    end

    // Occupancy bits and token valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
            r_vld  <= 1'b0;
        end else begin
            r_bits <= n_bits;
            r_vld  <= i_tok.vld;
        end
    end

    // Token payload.
    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    always_comb begin
        o_tok     = r_tok;
        o_tok.vld = r_vld;
    end

endmodule

### src/gsa_ctrl.sv
// ----------------------------------------------------------------------------
// Grid slot allocator controller
// Holds the configuration registers and the full flag, launches the search
// token, chooses the slot, works out its pixel position and returns results.
// ----------------------------------------------------------------------------
module gsa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gsa_req_if.sink           i_req,
    gsa_res_if.source         o_res,
    gsa_cfg_if.sink           i_cfg,
    input  gsa_pkg::t_token   i_tok_last,
    output gsa_pkg::t_token   o_tok_first,
    output gsa_pkg::t_row_wr  o_wr
);

    localparam int PX_W  = gsa_pkg::COL_W + gsa_pkg::STEP_W;
    localparam int PY_W  = gsa_pkg::ROW_W + 1 + gsa_pkg::STEP_W;
    localparam int MAXP_W = (PX_W > PY_W) ? PX_W : PY_W;
    localparam int SUM_W = ((MAXP_W > gsa_pkg::POS_W) ? MAXP_W : gsa_pkg::POS_W) + 2;
    localparam int POS_MAX = 32767;
    localparam int POS_MIN = -32768;

    // Configuration registers.
    logic [gsa_pkg::CNT_CFG_W-1:0]      r_cols_cfg;
    logic [gsa_pkg::CNT_CFG_W-1:0]      r_rows_cfg;
    logic signed [gsa_pkg::POS_W-1:0]   r_org_x;
    logic signed [gsa_pkg::POS_W-1:0]   r_org_y;
    logic [gsa_pkg::STEP_W-1:0]         r_step_x;
    logic [gsa_pkg::STEP_W-1:0]         r_step_y;
    logic signed [gsa_pkg::POS_W-1:0]   r_top;

    gsa_pkg::t_state                    r_state;
    gsa_pkg::t_state                    n_state;
    logic                               r_full;
    logic                               n_full;

    // Captured selection and products.
    gsa_pkg::t_op                       r_op;
    logic                               r_free_ok;
    logic                               r_sel_found;
    logic [gsa_pkg::COL_W-1:0]          r_sel_col;
    logic [gsa_pkg::ROW_W-1:0]          r_sel_row;
    logic [PX_W-1:0]                    r_prod_x;
    logic [PY_W-1:0]                    r_prod_y;

    // Output register.
    logic                               r_out_vld;
    logic                               r_out_ok;
    logic signed [gsa_pkg::POS_W-1:0]   r_out_x;
    logic signed [gsa_pkg::POS_W-1:0]   r_out_y;
    logic [gsa_pkg::SLOT_W-1:0]         r_out_col;
    logic [gsa_pkg::SLOT_W-1:0]         r_out_row;
    logic                               r_out_full;

    // Control strobes.
    logic                               accept;
    logic                               capture;
    logic                               multiply;
    logic                               finish;

    logic [gsa_pkg::CNT_C_W-1:0]        cols_eff;
    logic [gsa_pkg::CNT_R_W-1:0]        rows_eff;
    logic                               col_in_grid;
    logic                               row_in_grid;
    logic [gsa_pkg::COL_W-1:0]          hint_col;
    logic [gsa_pkg::ROW_W-1:0]          hint_row;
    logic                               use_hint;
    logic signed [SUM_W-1:0]            sum_x;
    logic signed [SUM_W-1:0]            sum_y;
    logic                               place_ok;

    function automatic logic signed [gsa_pkg::POS_W-1:0] sat_pos(logic signed [SUM_W-1:0] v);
        logic signed [gsa_pkg::POS_W-1:0] res;
        if (v > SUM_W'(POS_MAX)) begin
            res = gsa_pkg::POS_W'(POS_MAX);
        end else if (v < SUM_W'(POS_MIN)) begin
            res = gsa_pkg::POS_W'(POS_MIN);
        end else begin
            res = v[gsa_pkg::POS_W-1:0];
        end
        return res;
    endfunction

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_cfg <= gsa_pkg::CNT_CFG_W'(16);
            r_rows_cfg <= gsa_pkg::CNT_CFG_W'(16);
            r_org_x    <= '0;
            r_org_y    <= '0;
            r_step_x   <= gsa_pkg::STEP_W'(96);
            r_step_y   <= gsa_pkg::STEP_W'(96);
            r_top      <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                gsa_pkg::CFG_COLS:     r_cols_cfg <= i_cfg.data[gsa_pkg::CNT_CFG_W-1:0];
                gsa_pkg::CFG_ROWS:     r_rows_cfg <= i_cfg.data[gsa_pkg::CNT_CFG_W-1:0];
                gsa_pkg::CFG_ORIGIN_X: r_org_x    <= i_cfg.data;
                gsa_pkg::CFG_ORIGIN_Y: r_org_y    <= i_cfg.data;
                gsa_pkg::CFG_STEP_X:   r_step_x   <= i_cfg.data[gsa_pkg::STEP_W-1:0];
                gsa_pkg::CFG_STEP_Y:   r_step_y   <= i_cfg.data[gsa_pkg::STEP_W-1:0];
                gsa_pkg::CFG_TOP:      r_top      <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Columns and rows in use, limited to the stored grid.
    assign cols_eff = (32'(r_cols_cfg) > gsa_pkg::MAX_COLS) ?
                      gsa_pkg::CNT_C_W'(gsa_pkg::MAX_COLS) : gsa_pkg::CNT_C_W'(r_cols_cfg);
    assign rows_eff = (32'(r_rows_cfg) > gsa_pkg::MAX_ROWS) ?
                      gsa_pkg::CNT_R_W'(gsa_pkg::MAX_ROWS) : gsa_pkg::CNT_R_W'(r_rows_cfg);

    // Range checks on the requested slot.
    assign col_in_grid = !i_req.col[gsa_pkg::IN_W-1] &&
                         (32'(unsigned'(i_req.col)) < gsa_pkg::MAX_COLS);
    assign row_in_grid = !i_req.row[gsa_pkg::IN_W-1] &&
                         (32'(unsigned'(i_req.row)) < gsa_pkg::MAX_ROWS);
    assign hint_col    = gsa_pkg::COL_W'(unsigned'(i_req.col));
    assign hint_row    = gsa_pkg::ROW_W'(unsigned'(i_req.row));

    // Token launched into the first cell.
    always_comb begin
        o_tok_first           = '0;
        o_tok_first.vld       = accept;
        o_tok_first.op        = gsa_pkg::t_op'(i_req.op);
        o_tok_first.in_grid   = col_in_grid && row_in_grid;
        o_tok_first.hint_ok   = (i_req.op == gsa_pkg::OP_REQ) && col_in_grid && row_in_grid &&
                                (32'(hint_col) < 32'(cols_eff)) &&
                                (32'(hint_row) < 32'(rows_eff));
        o_tok_first.hcol      = hint_col;
        o_tok_first.hrow      = hint_row;
        o_tok_first.cols      = cols_eff;
        o_tok_first.rows      = rows_eff;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gsa_pkg::ST_IDLE: if (i_req.valid) n_state = gsa_pkg::ST_SCAN;
            gsa_pkg::ST_SCAN: if (i_tok_last.vld) n_state = gsa_pkg::ST_MUL;
            gsa_pkg::ST_MUL:  n_state = gsa_pkg::ST_DONE;
            gsa_pkg::ST_DONE: if (!r_out_vld || o_res.ready) n_state = gsa_pkg::ST_IDLE;
            default:          n_state = gsa_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        i_req.ready = 1'b0;
        capture     = 1'b0;
        multiply    = 1'b0;
        finish      = 1'b0;
        unique case (r_state)
            gsa_pkg::ST_IDLE: i_req.ready = 1'b1;
            gsa_pkg::ST_SCAN: capture     = i_tok_last.vld;
            gsa_pkg::ST_MUL:  multiply    = 1'b1;
            gsa_pkg::ST_DONE: finish      = !r_out_vld || o_res.ready;
            default: ;
        endcase
    end

    assign accept   = i_req.valid && i_req.ready;
    assign use_hint = i_tok_last.hint_ok && i_tok_last.hint_free;

    // Pixel position of the chosen slot.
    assign sum_x    = SUM_W'(r_org_x) + $signed(SUM_W'(r_prod_x));
    assign sum_y    = SUM_W'(r_org_y) - $signed(SUM_W'(r_prod_y));
    assign place_ok = r_sel_found && (sum_y > SUM_W'(r_top));

    always_comb begin
        n_full = r_full;
        if (finish && (r_op == gsa_pkg::OP_REQ) && !place_ok) begin
            n_full = 1'b1;
        end
    end

    // Slot marking once the request is placed.
    always_comb begin
        o_wr.en  = finish && (r_op == gsa_pkg::OP_REQ) && place_ok;
        o_wr.row = r_sel_row;
        o_wr.col = r_sel_col;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gsa_pkg::ST_IDLE;
            r_full    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_full  <= n_full;
            if (finish) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Selection, products and result payload.
    always_ff @(posedge i_clk) begin
        if (capture) begin
            r_op        <= i_tok_last.op;
            r_free_ok   <= i_tok_last.free_ok;
            r_sel_found <= use_hint || i_tok_last.ff_found;
            r_sel_col   <= use_hint ? i_tok_last.hcol : i_tok_last.ff_col;
            r_sel_row   <= use_hint ? i_tok_last.hrow : i_tok_last.ff_row;
        end
        if (multiply) begin
            r_prod_x <= PX_W'(r_sel_col) * PX_W'(r_step_x);
            r_prod_y <= (PY_W'(r_sel_row) + PY_W'(1)) * PY_W'(r_step_y);
        end
        if (finish) begin
            r_out_full <= n_full;
            if (r_op == gsa_pkg::OP_FREE) begin
                r_out_ok  <= r_free_ok;
                r_out_x   <= '0;
                r_out_y   <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else if (place_ok) begin
                r_out_ok  <= 1'b1;
                r_out_x   <= sat_pos(sum_x);
                r_out_y   <= sat_pos(sum_y);
                r_out_col <= gsa_pkg::SLOT_W'(r_sel_col);
                r_out_row <= gsa_pkg::SLOT_W'(r_sel_row);
            end else begin
                r_out_ok  <= 1'b0;
                r_out_x   <= '0;
                r_out_y   <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end
        end
    end

    assign o_res.valid    = r_out_vld;
    assign o_res.ok       = r_out_ok;
    assign o_res.pos_x    = r_out_x;
    assign o_res.pos_y    = r_out_y;
    assign o_res.slot_col = r_out_col;
    assign o_res.slot_row = r_out_row;
    assign o_res.full_res = r_out_full;

endmodule

### src/grid_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// Grid slot allocator
// Occupancy map of a slot grid with hinted first-fit placement and free.
//
//   Channel   Direction   Handshake        Payload
//   i_req     in          valid / ready    op, col, row
//   o_res     out         valid / ready    ok, pos_x, pos_y, slot_col,
//                                          slot_row, full_res
//   i_cfg     in          valid / ready    index, data
//
// One transaction at a time: the search token walks one row cell per cycle
// down the chain, then the controller forms the products in ST_MUL and
// places the slot in ST_DONE before the block is ready again.
// Reset empties the grid at once, clears the full flag and loads the
// register defaults. A stalled result holds in the output register; the
// next request is taken while it waits, and placement stalls behind it.
// ----------------------------------------------------------------------------
module grid_slot_allocator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gsa_req_if.sink     i_req,
    gsa_res_if.source   o_res,
    gsa_cfg_if.sink     i_cfg
);

    gsa_pkg::t_token  tok [gsa_pkg::MAX_ROWS+1];
    gsa_pkg::t_row_wr wr;

    // Controller with configuration and result registers.
    gsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_res       (o_res),
        .i_cfg       (i_cfg),
        .i_tok_last  (tok[gsa_pkg::MAX_ROWS]),
        .o_tok_first (tok[0]),
        .o_wr        (wr)
    );

    // Chain of row cells, one per stored grid row.
    for (genvar k = 0; k < gsa_pkg::MAX_ROWS; k++) begin : g_cell
        gsa_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_row_idx (gsa_pkg::ROW_W'(k)),
            .i_tok     (tok[k]),
            .i_wr      (wr),
            .o_tok     (tok[k+1])
        );
    end

endmodule

### src/gsa_checker.sv
// ----------------------------------------------------------------------------
// Grid slot allocator port checker
// Watches the top-level channels for result ordering and flag behaviour.
// ----------------------------------------------------------------------------
module gsa_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_req_valid,
    input logic                             i_req_ready,
    input logic                             i_res_valid,
    input logic                             i_res_ready,
    input logic                             i_res_ok,
    input logic signed [gsa_pkg::POS_W-1:0] i_res_pos_x,
    input logic                             i_res_full
);

    logic [1:0] r_pending;
    logic       r_seen_full;
    logic       req_acc;
    logic       res_acc;

    assign req_acc = i_req_valid && i_req_ready;
    assign res_acc = i_res_valid && i_res_ready;

    // Outstanding transactions and the sticky flag as seen on the ports.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= '0;
            r_seen_full <= 1'b0;
        end else begin
            r_pending <= r_pending + 2'(req_acc) - 2'(res_acc);
            if (res_acc && i_res_full) begin
                r_seen_full <= 1'b1;
            end
        end
    end

    // A stalled result holds its payload.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_res_ok) && $stable(i_res_pos_x) && $stable(i_res_full))
        else $error("result changed while stalled");

    // No result appears without a request behind it.
    a_res_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> r_pending != 2'd0)
        else $error("result without an outstanding request");

    // Once reported, the full flag stays set.
    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && r_seen_full |-> i_res_full)
        else $error("full flag cleared");

    // A request is never taken back to back with another.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> !i_req_ready)
        else $error("request taken back to back");

endmodule

bind grid_slot_allocator_unit gsa_checker u_gsa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_ok    (o_res.ok),
    .i_res_pos_x (o_res.pos_x),
    .i_res_full  (o_res.full_res)
);
